// ===== sv/skte_pkg.sv =====
`timescale 1ns / 1ps

package skte_pkg;

	localparam int CAPACITY = 4096;
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int KIND_W   = 3;
	localparam int KEY_W    = 15;
	localparam int PAY_W    = 32;
	localparam int STAT_W   = 2;
	localparam int POS_W    = 12;
	localparam int HELD_W   = 13;
	localparam int ENT_W    = KEY_W + PAY_W;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] K_DELETE = 3'd1;
	localparam logic [KIND_W-1:0] K_FIND   = 3'd2;
	localparam logic [KIND_W-1:0] K_NEXT   = 3'd3;
	localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

// ===== sv/skte_ram.sv =====
`timescale 1ns / 1ps

module skte_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((D > 2) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic                                re,
	input  logic [((D > 2) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sorted_key_table_engine.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata                                            tuser
// s_axis    in   key[14:0] payload[46:15] (zero to 48 bits)       kind[2:0]
// m_axis    out  position[11:0] found_key[26:12]                  status[1:0]
//                found_payload[58:27] entries_held[71:59]
//
// Each request runs binary-search steps through the single table RAM read port,
// then a probe; a new insert and a delete move the entries above the slot one per
// cycle, and insert then writes the new entry. Clear and unused kinds go straight
// to the finish step.
// Reset clears the sequencer and the entry count; the RAM keeps no reset.
// s_tready is high only in the idle state; a result held in the output register
// does not stop the next transfer, but the finish step waits for it to be taken.

module sorted_key_table_engine
	import skte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // key, payload, zero fill
	input  logic [KIND_W-1:0]     s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // position, found_key, found_payload, entries_held
	output logic [STAT_W-1:0]     m_tuser    // status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_SWAIT = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_UP   = 3'd4;
	localparam logic [2:0] S_DOWN = 3'd5;
	localparam logic [2:0] S_PUT  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]        state_q;
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lo_q, hi_q;
	logic [IDX_W-1:0]  mid_q;
	logic              inrange_q;
	logic [IDX_W-1:0]  src_q, dst_q;
	logic              more_q, pend_q;

	logic [STAT_W-1:0] rstat_q;
	logic [IDX_W-1:0]  rpos_q;
	logic [KEY_W-1:0]  rkey_q;
	logic [PAY_W-1:0]  rpay_q;

	logic              out_v_q;
	logic [STAT_W-1:0] o_stat_q;
	logic [POS_W-1:0]  o_pos_q;
	logic [KEY_W-1:0]  o_key_q;
	logic [PAY_W-1:0]  o_pay_q;
	logic [HELD_W-1:0] o_held_q;

	logic              we, re;
	logic [IDX_W-1:0]  waddr, raddr;
	entry_t            wdata, rdata;

	logic [CNT_W-1:0]  mid;
	logic              hit;
	logic [CNT_W-1:0]  lo_next;
	logic              out_free;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_next = {1'b0, lo_q[IDX_W-1:0]} + CNT_W'(1);
	assign hit = inrange_q && (rdata.key == key_q);
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// RAM port steering
	always_comb begin
		we    = 1'b0;
		waddr = dst_q;
		wdata = rdata;
		re    = 1'b0;
		raddr = src_q;
		unique case (state_q)
			S_SRCH: begin
				re    = 1'b1;
				raddr = (lo_q < hi_q) ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
				if (!(lo_q < hi_q) && !(lo_q < count_q)) begin
					re = 1'b0;
				end
			end
			S_CHK: begin
				if (kind_q == K_INSERT && hit) begin
					we    = 1'b1;
					waddr = rpos_q;
					wdata = '{key: key_q, payload: pay_q};
				end
			end
			S_UP, S_DOWN: begin
				we = pend_q;
				re = more_q;
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = rpos_q;
				wdata = '{key: key_q, payload: pay_q};
			end
			default: begin
			end
		endcase
	end

	skte_ram #(.W(ENT_W), .D(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			more_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser;
						key_q   <= s_tdata[KEY_W-1:0];
						pay_q   <= s_tdata[ENT_W-1:KEY_W];
						lo_q    <= '0;
						hi_q    <= count_q;
						rstat_q <= ST_OK;
						rpos_q  <= '0;
						rkey_q  <= '0;
						rpay_q  <= '0;
						if (s_tuser == K_CLEAR) begin
							count_q <= '0;
							state_q <= S_DONE;
						end else if (s_tuser > K_CLEAR) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid[IDX_W-1:0];
						state_q <= S_SWAIT;
					end else begin
						inrange_q <= (lo_q < count_q);
						rpos_q    <= lo_q[IDX_W-1:0];
						state_q   <= S_CHK;
					end
				end
				S_SWAIT: begin
					if (rdata.key < key_q) begin
						lo_q <= {1'b0, mid_q} + CNT_W'(1);
					end else begin
						hi_q <= {1'b0, mid_q};
					end
					state_q <= S_SRCH;
				end
				S_CHK: begin
					pend_q <= 1'b0;
					unique case (kind_q)
						K_INSERT: begin
							if (hit) begin
								rstat_q <= ST_OK;
								state_q <= S_DONE;
							end else if (count_q >= CNT_W'(CAPACITY)) begin
								rstat_q <= ST_FULL;
								rpos_q  <= '0;
								state_q <= S_DONE;
							end else begin
								// shift from the top entry down to the insert point
								src_q   <= IDX_W'(count_q - CNT_W'(1));
								more_q  <= (count_q > {1'b0, rpos_q});
								state_q <= S_UP;
							end
						end
						K_DELETE: begin
							if (hit) begin
								src_q   <= lo_next[IDX_W-1:0];
								more_q  <= (lo_next < count_q);
								state_q <= S_DOWN;
							end else begin
								rstat_q <= ST_MISS;
								rpos_q  <= '0;
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
							if ((kind_q == K_FIND) ? hit : inrange_q) begin
								rkey_q <= rdata.key;
								rpay_q <= rdata.payload;
							end else begin
								rstat_q <= ST_MISS;
								rpos_q  <= '0;
							end
						end
					endcase
				end
				S_UP: begin
					if (more_q) begin
						dst_q  <= src_q + IDX_W'(1);
						pend_q <= 1'b1;
						more_q <= (src_q != rpos_q);
						src_q  <= src_q - IDX_W'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_PUT;
					end
				end
				S_DOWN: begin
					if (more_q) begin
						dst_q  <= src_q - IDX_W'(1);
						pend_q <= 1'b1;
						more_q <= (({1'b0, src_q} + CNT_W'(1)) < count_q);
						src_q  <= src_q + IDX_W'(1);
					end else begin
						pend_q  <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_stat_q <= rstat_q;
			o_pos_q  <= POS_W'(rpos_q);
			o_key_q  <= rkey_q;
			o_pay_q  <= rpay_q;
			o_held_q <= HELD_W'(count_q);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = o_stat_q;
	assign m_tdata  = {o_held_q, o_pay_q, o_key_q, o_pos_q};

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we)
		else $error("table write while idle");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == K_CLEAR |=> count_q == '0)
		else $error("clear left entries");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[POS_W-1:0] == '0)
		else $error("position set on failed operation");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_v_q && !m_tready |=> state_q == S_DONE)
		else $error("result overwrote an untaken transfer");

endmodule

// ===== test/skte_reply_check.sv =====
`timescale 1ns / 1ps

module skte_reply_check
	import skte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // key, payload, zero fill
	input  logic [KIND_W-1:0]     s_tuser,   // kind
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // position, found_key, found_payload, entries_held
	input  logic [STAT_W-1:0]     m_tuser,   // status
	output int                    failures,
	output int                    outstanding,
	output int                    replies_seen
);

	localparam int FKEY_LSB = POS_W;
	localparam int FPAY_LSB = FKEY_LSB + KEY_W;
	localparam int HELD_LSB = FPAY_LSB + PAY_W;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		logic [KEY_W-1:0]  found_key;
		logic [PAY_W-1:0]  found_payload;
		logic [HELD_W-1:0] entries_held;
	} reply_t;

	// shadow copy of the table
	logic [KEY_W-1:0] key_tab [CAPACITY];
	logic [PAY_W-1:0] pay_tab [CAPACITY];
	int unsigned      held;
	reply_t           pending_replies [$];
	reply_t           oldest;

	// first slot whose key is at or above k, or held when there is none
	function automatic int unsigned lower_slot(input logic [KEY_W-1:0] k);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = held;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (key_tab[IDX_W'(mid)] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic reply_t apply_request(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		reply_t      r;
		int unsigned slot;
		int unsigned i;
		bit          hit;
		r    = '0;
		slot = lower_slot(key);
		hit  = (slot < held) && (key_tab[IDX_W'(slot)] == key);
		case (kind)
			K_INSERT: begin
				if (hit) begin
					pay_tab[IDX_W'(slot)] = pay;
					r.position            = slot[POS_W-1:0];
				end else if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = held; i > slot; i--) begin
						key_tab[IDX_W'(i)] = key_tab[IDX_W'(i-1)];
						pay_tab[IDX_W'(i)] = pay_tab[IDX_W'(i-1)];
					end
					key_tab[IDX_W'(slot)] = key;
					pay_tab[IDX_W'(slot)] = pay;
					held++;
					r.position = slot[POS_W-1:0];
				end
			end
			K_DELETE: begin
				if (hit) begin
					for (i = slot; i + 1 < held; i++) begin
						key_tab[IDX_W'(i)] = key_tab[IDX_W'(i+1)];
						pay_tab[IDX_W'(i)] = pay_tab[IDX_W'(i+1)];
					end
					held--;
					r.position = slot[POS_W-1:0];
				end else begin
					r.status = ST_MISS;
				end
			end
			K_FIND, K_NEXT: begin
				if ((kind == K_FIND) ? hit : (slot < held)) begin
					r.position      = slot[POS_W-1:0];
					r.found_key     = key_tab[IDX_W'(slot)];
					r.found_payload = pay_tab[IDX_W'(slot)];
				end else begin
					r.status = ST_MISS;
				end
			end
			K_CLEAR: begin
				held = 0;
			end
			default: ;
		endcase
		r.entries_held = held[HELD_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [PAY_W-1:0] want,
			input logic [PAY_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			pending_replies.delete();
			outstanding = 0;
		end else begin
			// retire a reply before queuing a new request taken on the same edge
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					$error("reply transfer with no request outstanding");
					failures++;
				end else begin
					oldest = pending_replies.pop_front();
					check_field("status", PAY_W'(oldest.status), PAY_W'(m_tuser));
					check_field("position", PAY_W'(oldest.position),
						PAY_W'(m_tdata[POS_W-1:0]));
					check_field("found_key", PAY_W'(oldest.found_key),
						PAY_W'(m_tdata[FKEY_LSB +: KEY_W]));
					check_field("found_payload", oldest.found_payload,
						m_tdata[FPAY_LSB +: PAY_W]);
					check_field("entries_held", PAY_W'(oldest.entries_held),
						PAY_W'(m_tdata[HELD_LSB +: HELD_W]));
					replies_seen++;
				end
			end
			if (s_tvalid && s_tready)
				pending_replies.push_back(apply_request(s_tuser, s_tdata[KEY_W-1:0],
					s_tdata[KEY_W +: PAY_W]));
			outstanding = pending_replies.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import skte_pkg::*;

	// kind codes the block ignores
	localparam logic [KIND_W-1:0] K_SPARE5 = 3'd5;
	localparam logic [KIND_W-1:0] K_SPARE6 = 3'd6;
	localparam logic [KIND_W-1:0] K_SPARE7 = 3'd7;

	localparam int RUN_LIMIT    = 1_500_000;
	localparam int RANDOM_ITEMS = 110;
	localparam int QUIET_TAIL   = 40;
	localparam int POOL_SIZE    = 24;
	localparam int POOL_W       = $clog2(POOL_SIZE);
	localparam int KEY_MAX      = (1 << KEY_W) - 1;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [KIND_W-1:0]     s_tuser  = '0;
	logic                  m_tready = 1'b0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	int failures;
	int outstanding;
	int replies_seen;
	int cycle_count = 0;
	int issued      = 0;
	int sink_hold   = 0;
	bit allow_idle  = 1'b1;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always #10 clk = ~clk;

	sorted_key_table_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	skte_reply_check reply_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.failures     (failures),
		.outstanding  (outstanding),
		.replies_seen (replies_seen)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// reply side: random stall bursts, none once idle cycles are turned off
	always @(negedge clk) begin
		if (!allow_idle) begin
			m_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			sink_hold = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic issue(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay);
		int gap;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, pay, key};
		do @(posedge clk); while (!s_tready);
		issued++;
	endtask

	initial begin
		int               i;
		int               r;
		int               counted;
		logic [KEY_W-1:0] k;
		logic [KIND_W-1:0] kd;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, field extremes, replace, misses, ignored kinds
		issue(K_FIND, '0, '0);
		issue(K_NEXT, '0, '1);
		issue(K_DELETE, KEY_W'(KEY_MAX), '0);
		issue(K_INSERT, KEY_W'(KEY_MAX), '1);
		issue(K_INSERT, '0, '0);
		issue(K_INSERT, 15'd100, $urandom());
		issue(K_INSERT, 15'd100, 32'hA5A5_5A5A);
		issue(K_FIND, 15'd100, '0);
		issue(K_FIND, 15'd101, '0);
		issue(K_NEXT, 15'd101, '0);
		issue(K_NEXT, '0, '0);
		issue(K_FIND, KEY_W'(KEY_MAX), '0);
		issue(K_DELETE, 15'd100, '0);
		issue(K_DELETE, 15'd100, '0);
		issue(K_SPARE5, 15'd7, $urandom());
		issue(K_SPARE6, KEY_W'(KEY_MAX), '1);
		issue(K_SPARE7, '0, '0);
		issue(K_CLEAR, KEY_W'(KEY_MAX), '1);
		issue(K_NEXT, 15'd5, '0);

		// random traffic around a small key set so that hits are common
		for (i = 0; i < POOL_SIZE; i++)
			key_pool[POOL_W'(i)] = KEY_W'($urandom_range(0, KEY_MAX));
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted >= RANDOM_ITEMS - QUIET_TAIL)
				allow_idle = 1'b0;
			if ($urandom_range(0, 4) == 0)
				k = KEY_W'($urandom_range(0, KEY_MAX));
			else
				k = key_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
			r = $urandom_range(0, 99);
			if (r < 38)
				kd = K_INSERT;
			else if (r < 58)
				kd = K_DELETE;
			else if (r < 73)
				kd = K_FIND;
			else if (r < 88)
				kd = K_NEXT;
			else if (r < 92)
				kd = K_CLEAR;
			else begin
				case ($urandom_range(0, 2))
					0:       kd = K_SPARE5;
					1:       kd = K_SPARE6;
					default: kd = K_SPARE7;
				endcase
			end
			issue(kd, k, $urandom());
			if (kd <= K_CLEAR)
				counted++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (64) @(posedge clk);

		$display("%0d requests sent: edge keys, replace, misses, ignored kinds and clears",
			issued);
		$display("%0d replies compared with the predicted table", replies_seen);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
